// File: src/nd_tensor_slice_filter_top_macros.svh
// assertion helpers, sampled on clk and held off while rst_n is low
`ifndef ND_TENSOR_SLICE_FILTER_TOP_MACROS_SVH
`define ND_TENSOR_SLICE_FILTER_TOP_MACROS_SVH

// consequent checked in the same cycle
`define NTS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define NTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/nts_pkg.sv
`default_nettype none

package nts_pkg;

  localparam int MAX_DIMS   = 4;
  localparam int COORD_BITS = 16;
  localparam int DATA_BITS  = 32;
  localparam int FIELD_BITS = 16;
  localparam int DIM_BITS   = 2;
  localparam int NDIM_BITS  = 3;
  localparam int SIZE_BITS  = COORD_BITS + 1;
  localparam int CFG_BITS   = 64;
  localparam int IDX_BITS   = 3;

  typedef enum logic [IDX_BITS-1:0] {
    CFG_NUM_DIMS   = 3'd0,
    CFG_DIM_SIZES  = 3'd1,
    CFG_LOWER      = 3'd2,
    CFG_UPPER      = 3'd3,
    CFG_LOWER_MASK = 3'd4,
    CFG_UPPER_MASK = 3'd5,
    CFG_SLICE_MAP  = 3'd6
  } cfg_idx_t;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [SIZE_BITS-1:0]  size_t;

  // per-dimension view of the configuration
  typedef struct packed {
    logic [NDIM_BITS-1:0]                  ndims;
    logic [MAX_DIMS-1:0]                   used;
    logic [MAX_DIMS-1:0][SIZE_BITS-1:0]    size;
    logic [MAX_DIMS-1:0]                   lo_on;
    logic [MAX_DIMS-1:0]                   hi_on;
    logic [MAX_DIMS-1:0][FIELD_BITS-1:0]   lo;
    logic [MAX_DIMS-1:0][FIELD_BITS-1:0]   hi;
  } dim_cfg_t;

  typedef struct packed {
    logic kept;
    logic at_end;
  } chk_res_t;

endpackage

`default_nettype wire

// File: src/nts_if.sv
`default_nettype none

interface nts_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [nts_pkg::DATA_BITS-1:0] value;
  logic                                 last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface nts_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [nts_pkg::DATA_BITS-1:0] kept_value;
  logic                                 last_kept;

  modport source (output valid, output kept_value, output last_kept, input ready);
  modport sink (input valid, input kept_value, input last_kept, output ready);
endinterface

`default_nettype wire

// File: src/nd_tensor_slice_filter_top.sv
// channel  dir  handshake     payload
// in_s     in   valid/ready   value (32b signed), last
// out_m    out  valid/ready   kept_value (32b signed), last_kept
// cfg_*    in   cfg_we        cfg_index (3b), cfg_wdata (64b)
//
// one element accepted per cycle while in_s.ready is high; a kept element is held
// in one output register for out_m; coordinate compare and carry are combinational
// in_s.ready drops only while a result sits in the output register and out_m stalls
// synchronous active-low reset: coordinates zero, output empty, registers to defaults
`default_nettype none

`include "nd_tensor_slice_filter_top_macros.svh"

module nd_tensor_slice_filter_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  nts_in_if.sink                             in_s,
  nts_out_if.source                          out_m,
  input  wire logic                          cfg_we,
  input  wire logic [nts_pkg::IDX_BITS-1:0]  cfg_index,
  input  wire logic [nts_pkg::CFG_BITS-1:0]  cfg_wdata
);

  nts_pkg::dim_cfg_t                               dcfg;
  nts_pkg::coord_t [nts_pkg::MAX_DIMS-1:0]         coord;
  nts_pkg::chk_res_t                               res;

  logic                                 in_acc;
  logic                                 out_valid_r;
  logic                                 out_valid_nxt;
  logic signed [nts_pkg::DATA_BITS-1:0] out_value_r;
  logic                                 out_last_r;

  nts_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .dcfg      (dcfg)
  );

  nts_coord_ctr u_coord (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (in_acc),
    .restart (in_s.last),
    .dcfg    (dcfg),
    .coord   (coord)
  );

  nts_region_chk u_chk (
    .dcfg  (dcfg),
    .coord (coord),
    .res   (res)
  );

  assign in_s.ready = !out_valid_r || out_m.ready;
  assign in_acc     = in_s.valid && in_s.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = res.kept;
    end else if (out_m.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res.kept) begin
      out_value_r <= in_s.value;
      out_last_r  <= res.at_end;
    end
  end

  assign out_m.valid      = out_valid_r;
  assign out_m.kept_value = out_value_r;
  assign out_m.last_kept  = out_last_r;

  `NTS_ASSERT_SAME(a_stall_blocks_in, out_valid_r && !out_m.ready, !in_s.ready,
                   "request taken while result register is stalled")
  `NTS_ASSERT_NEXT(a_kept_shows, in_acc && res.kept,
                   out_valid_r && out_value_r == $past(in_s.value),
                   "kept element missing from output")
  `NTS_ASSERT_NEXT(a_dropped_silent, in_acc && !res.kept, !out_valid_r,
                   "result produced for an element outside the region")

endmodule

`default_nettype wire

// File: src/nts_cfg_regs.sv
`default_nettype none

module nts_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [nts_pkg::IDX_BITS-1:0]       cfg_index,
  input  wire logic [nts_pkg::CFG_BITS-1:0]       cfg_wdata,
  output nts_pkg::dim_cfg_t                       dcfg
);

  localparam int MD = nts_pkg::MAX_DIMS;
  localparam int FB = nts_pkg::FIELD_BITS;

  logic [nts_pkg::NDIM_BITS-1:0]   num_dims_r;
  logic [nts_pkg::CFG_BITS-1:0]    sizes_r;
  logic [nts_pkg::CFG_BITS-1:0]    lower_r;
  logic [nts_pkg::CFG_BITS-1:0]    upper_r;
  logic [MD-1:0]                   lo_mask_r;
  logic [MD-1:0]                   hi_mask_r;
  logic [MD*nts_pkg::DIM_BITS-1:0] map_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r <= nts_pkg::NDIM_BITS'(1);
      sizes_r    <= 64'h0001_0001_0001_0001;
      lower_r    <= '0;
      upper_r    <= '0;
      lo_mask_r  <= '0;
      hi_mask_r  <= '0;
      map_r      <= 8'hE4;
    end else if (cfg_we) begin
      unique case (nts_pkg::cfg_idx_t'(cfg_index))
        nts_pkg::CFG_NUM_DIMS:   num_dims_r <= cfg_wdata[nts_pkg::NDIM_BITS-1:0];
        nts_pkg::CFG_DIM_SIZES:  sizes_r    <= cfg_wdata;
        nts_pkg::CFG_LOWER:      lower_r    <= cfg_wdata;
        nts_pkg::CFG_UPPER:      upper_r    <= cfg_wdata;
        nts_pkg::CFG_LOWER_MASK: lo_mask_r  <= cfg_wdata[MD-1:0];
        nts_pkg::CFG_UPPER_MASK: hi_mask_r  <= cfg_wdata[MD-1:0];
        nts_pkg::CFG_SLICE_MAP:  map_r      <= cfg_wdata[MD*nts_pkg::DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic [FB-1:0] size_raw;

  always_comb begin
    dcfg = '0;
    size_raw = '0;
    // clamp the dimension count into 1..MAX_DIMS
    if (num_dims_r == '0) begin
      dcfg.ndims = nts_pkg::NDIM_BITS'(1);
    end else if (num_dims_r > nts_pkg::NDIM_BITS'(MD)) begin
      dcfg.ndims = nts_pkg::NDIM_BITS'(MD);
    end else begin
      dcfg.ndims = num_dims_r;
    end
    for (int d = 0; d < MD; d++) begin
      dcfg.used[d] = (nts_pkg::NDIM_BITS'(d) < dcfg.ndims);
      size_raw = sizes_r[d*FB +: FB];
      // zero size stands for the full coordinate range
      if (size_raw[nts_pkg::COORD_BITS-1:0] == '0) begin
        dcfg.size[d] = nts_pkg::SIZE_BITS'(1) << nts_pkg::COORD_BITS;
      end else begin
        dcfg.size[d] = {1'b0, size_raw[nts_pkg::COORD_BITS-1:0]};
      end
    end
    // higher slice position overrides lower ones on the same dimension
    for (int d = 0; d < MD; d++) begin
      for (int s = 0; s < MD; s++) begin
        if (dcfg.used[s] && dcfg.used[d] &&
            map_r[s*nts_pkg::DIM_BITS +: nts_pkg::DIM_BITS] ==
            nts_pkg::DIM_BITS'(d)) begin
          dcfg.lo_on[d] = lo_mask_r[s];
          dcfg.hi_on[d] = hi_mask_r[s];
          dcfg.lo[d]    = lower_r[s*FB +: FB];
          dcfg.hi[d]    = upper_r[s*FB +: FB];
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: src/nts_coord_ctr.sv
`default_nettype none

`include "nd_tensor_slice_filter_top_macros.svh"

module nts_coord_ctr (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 adv,
  input  wire logic                                 restart,
  input  wire nts_pkg::dim_cfg_t                    dcfg,
  output nts_pkg::coord_t [nts_pkg::MAX_DIMS-1:0]   coord
);

  localparam int MD = nts_pkg::MAX_DIMS;

  nts_pkg::coord_t [MD-1:0] coord_r;
  nts_pkg::coord_t [MD-1:0] coord_nxt;
  logic [MD-1:0]            wrap;
  nts_pkg::size_t [MD-1:0]  inc;
  logic                     carry;

  always_comb begin
    coord_nxt = coord_r;
    carry     = 1'b1;
    for (int k = 0; k < MD; k++) begin
      inc[k]  = {1'b0, coord_r[k]} + nts_pkg::SIZE_BITS'(1);
      wrap[k] = (inc[k] >= dcfg.size[k]);
    end
    // last dimension in use runs fastest
    for (int k = MD - 1; k >= 0; k--) begin
      if (dcfg.used[k]) begin
        if (carry) begin
          coord_nxt[k] = wrap[k] ? '0 : inc[k][nts_pkg::COORD_BITS-1:0];
        end
        carry = carry & wrap[k];
      end
    end
    if (restart) begin
      coord_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_r <= '0;
    end else if (adv) begin
      coord_r <= coord_nxt;
    end
  end

  assign coord = coord_r;

  `NTS_ASSERT_NEXT(a_restart_clears, adv && restart, coord_r == '0,
                   "coordinates not cleared after final element")
  `NTS_ASSERT_NEXT(a_hold_idle, !adv, $stable(coord_r),
                   "coordinates moved without a request")
  `NTS_ASSERT_NEXT(a_fast_dim_moves,
                   adv && !restart && dcfg.ndims == nts_pkg::NDIM_BITS'(1) && !wrap[0],
                   coord_r[0] == $past(coord_r[0]) + nts_pkg::COORD_BITS'(1),
                   "single dimension did not step")

endmodule

`default_nettype wire

// File: src/nts_region_chk.sv
`default_nettype none

module nts_region_chk (
  input  wire nts_pkg::dim_cfg_t                         dcfg,
  input  wire nts_pkg::coord_t [nts_pkg::MAX_DIMS-1:0]   coord,
  output nts_pkg::chk_res_t                              res
);

  localparam int MD = nts_pkg::MAX_DIMS;

  nts_pkg::size_t [MD-1:0] c_ext;
  nts_pkg::size_t [MD-1:0] lo_ext;
  nts_pkg::size_t [MD-1:0] hi_ext;
  nts_pkg::size_t [MD-1:0] top;

  always_comb begin
    res.kept   = 1'b1;
    res.at_end = 1'b1;
    for (int d = 0; d < MD; d++) begin
      c_ext[d]  = {1'b0, coord[d]};
      lo_ext[d] = nts_pkg::SIZE_BITS'(dcfg.lo[d]);
      hi_ext[d] = nts_pkg::SIZE_BITS'(dcfg.hi[d]);
      top[d]    = dcfg.size[d];
      if (dcfg.hi_on[d] && hi_ext[d] < top[d]) begin
        top[d] = hi_ext[d];
      end
      if (dcfg.used[d]) begin
        if (dcfg.lo_on[d] && c_ext[d] < lo_ext[d]) res.kept = 1'b0;
        if (dcfg.hi_on[d] && c_ext[d] >= hi_ext[d]) res.kept = 1'b0;
        if (c_ext[d] + nts_pkg::SIZE_BITS'(1) != top[d]) res.at_end = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
